// File: src/xsp_pkg.sv
// Shared types and constants for the xorshift128+ generator with seed save.
`timescale 1ns / 1ps
`default_nettype none

package xsp_pkg;

   localparam int WORD_W = 64;
   localparam int SEED_W = 32;
   localparam int HALF_W = 32;
   localparam int CNT_W  = $clog2(WORD_W);

   localparam logic [WORD_W-1:0] MULT_A  = 64'h5851_F42D_4C95_7F2D;
   localparam logic [WORD_W-1:0] MULT_B  = 64'h1405_7B7E_F767_814F;
   localparam logic [WORD_W-1:0] WORD_ONE = 64'd1;

   typedef enum logic [1:0] {
      CMD_RAW     = 2'd0,
      CMD_MOD     = 2'd1,
      CMD_SEED    = 2'd2,
      CMD_RESTORE = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_DIV_DONE,
      ST_MUL,
      ST_MUL_LAST
   } state_type;

   typedef enum logic [1:0] {
      OUT_SUM,
      OUT_ZERO,
      OUT_REM
   } out_sel_type;

   typedef struct packed {
      logic        step;
      logic        div_init;
      logic        div_iter;
      logic        save_seed;
      logic        restore;
      logic        mul_en;
      logic [1:0]  mul_idx;
      logic        acc_en;
      logic [1:0]  acc_idx;
      logic        out_en;
      out_sel_type out_sel;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

// File: src/xsp_ctrl.sv
// Command sequencer: accepts transactions and steps the datapath through each command.
`timescale 1ns / 1ps
`default_nettype none

module xsp_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  xsp_pkg::command_type req_command,
   input  wire                  mod_ok,
   output logic                 busy,
   output xsp_pkg::ctrl_cmd_type cmd
);
   import xsp_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(3);

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               if (req_command == CMD_MOD && mod_ok) begin
                  state_in = ST_DIV;
               end else if (req_command == CMD_SEED) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_DIV_DONE;
            end
         end
         ST_DIV_DONE: begin
            state_in = ST_IDLE;
         end
         ST_MUL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               state_in = ST_MUL_LAST;
            end
         end
         ST_MUL_LAST: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.out_sel = OUT_ZERO;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_RAW: begin
                     cmd.step    = 1'b1;
                     cmd.out_en  = 1'b1;
                     cmd.out_sel = OUT_SUM;
                  end
                  CMD_MOD: begin
                     if (mod_ok) begin
                        cmd.step     = 1'b1;
                        cmd.div_init = 1'b1;
                     end else begin
                        cmd.out_en = 1'b1;
                     end
                  end
                  CMD_SEED: begin
                     cmd.save_seed = 1'b1;
                  end
                  CMD_RESTORE: begin
                     cmd.restore = 1'b1;
                     cmd.out_en  = 1'b1;
                  end
                  default: begin
                     cmd.out_en = 1'b1;
                  end
               endcase
            end
         end
         ST_DIV: begin
            cmd.div_iter = 1'b1;
         end
         ST_DIV_DONE: begin
            cmd.out_en  = 1'b1;
            cmd.out_sel = OUT_REM;
         end
         ST_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_idx = cnt_ff[1:0];
            cmd.acc_en  = (cnt_ff[1:0] != 2'd0);
            cmd.acc_idx = cnt_ff[1:0] - 2'd1;
         end
         ST_MUL_LAST: begin
            cmd.acc_en  = 1'b1;
            cmd.acc_idx = 2'd3;
            cmd.out_en  = 1'b1;
         end
         default: begin
            cmd.out_en = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: src/xsp_datapath.sv
// Generator state, saved copy, seeding multiplier, radix-2 divider and result register.
`timescale 1ns / 1ps
`default_nettype none

module xsp_datapath (
   input  wire                          clock,
   input  wire                          reset,
   input  wire  [xsp_pkg::SEED_W-1:0]   req_seed,
   input  wire  signed [xsp_pkg::WORD_W-1:0] req_modulus,
   input  xsp_pkg::ctrl_cmd_type        cmd,
   output logic                         mod_ok,
   output logic                         rsp_valid,
   output logic [xsp_pkg::WORD_W-1:0]   rsp_value
);
   import xsp_pkg::*;

   logic [WORD_W-1:0] gen0_ff, gen0_in, gen1_ff, gen1_in;
   logic [WORD_W-1:0] sav0_ff, sav1_ff;
   logic [SEED_W-1:0] ha_ff, hb_ff;
   logic [WORD_W-1:0] prod_ff;
   logic [WORD_W-1:0] dvd_ff, dvs_ff, rem_ff;
   logic [WORD_W-1:0] value_ff;
   logic              valid_ff;

   logic [WORD_W-1:0] x1, step1, sum;
   logic [HALF_W-1:0] mul_a, mul_b;
   logic [WORD_W-1:0] rem_shift, rem_next;

   assign mod_ok = !req_modulus[WORD_W-1] && (req_modulus != '0);

   assign x1    = gen0_ff ^ (gen0_ff << 23);
   assign step1 = x1 ^ gen1_ff ^ (x1 >> 17) ^ (gen1_ff >> 26);
   assign sum   = step1 + gen1_ff;

   always_comb begin
      case (cmd.mul_idx)
         2'd0: begin
            mul_a = MULT_A[HALF_W-1:0];
            mul_b = ha_ff;
         end
         2'd1: begin
            mul_a = MULT_A[WORD_W-1:HALF_W];
            mul_b = ha_ff;
         end
         2'd2: begin
            mul_a = MULT_B[HALF_W-1:0];
            mul_b = hb_ff;
         end
         default: begin
            mul_a = MULT_B[WORD_W-1:HALF_W];
            mul_b = hb_ff;
         end
      endcase
   end

   assign rem_shift = {rem_ff[WORD_W-2:0], dvd_ff[WORD_W-1]};
   assign rem_next  = (rem_shift >= dvs_ff) ? rem_shift - dvs_ff : rem_shift;

   always_comb begin
      gen0_in = gen0_ff;
      gen1_in = gen1_ff;
      if (cmd.step) begin
         gen0_in = gen1_ff;
         gen1_in = step1;
      end else if (cmd.restore) begin
         gen0_in = sav0_ff;
         gen1_in = sav1_ff;
      end else if (cmd.acc_en) begin
         case (cmd.acc_idx)
            2'd0:    gen0_in = prod_ff + WORD_ONE;
            2'd1:    gen0_in = gen0_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
            2'd2:    gen1_in = prod_ff + WORD_ONE;
            default: gen1_in = gen1_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen0_ff  <= WORD_ONE;
         gen1_ff  <= WORD_ONE;
         sav0_ff  <= WORD_ONE;
         sav1_ff  <= WORD_ONE;
         valid_ff <= 1'b0;
      end else begin
         gen0_ff  <= gen0_in;
         gen1_ff  <= gen1_in;
         valid_ff <= cmd.out_en;
         if (cmd.save_seed) begin
            sav0_ff <= gen0_ff;
            sav1_ff <= gen1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.save_seed) begin
         ha_ff <= req_seed ^ (req_seed >> 30);
         hb_ff <= req_seed ^ (req_seed >> 27);
      end
      if (cmd.mul_en) begin
         prod_ff <= {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
      end
      if (cmd.div_init) begin
         dvd_ff <= sum;
         dvs_ff <= req_modulus;
         rem_ff <= '0;
      end else if (cmd.div_iter) begin
         dvd_ff <= dvd_ff << 1;
         rem_ff <= rem_next;
      end
      if (cmd.out_en) begin
         case (cmd.out_sel)
            OUT_SUM:  value_ff <= sum;
            OUT_REM:  value_ff <= rem_ff;
            default:  value_ff <= '0;
         endcase
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_value = value_ff;

endmodule

`default_nettype wire

// File: src/xorshift_prng_with_seed_save_core.sv
// Top level of the xorshift128+ generator with seed save and restore.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Issue a transaction by raising start with req_command, req_seed and
//   req_modulus; it is taken at a clock edge where busy is low.
//   Each transaction returns one rsp_value, marked by rsp_valid for exactly
//   one cycle. The receiver cannot stall; it must take the result then.
// Timing per command:
//   Raw step, restore, and modulo with a modulus of zero or less: result in the
//   cycle after acceptance, busy stays low, one transaction per cycle.
//   Modulo with a positive modulus: the result comes from the radix-2 divider,
//   which retires one quotient bit per cycle over all 64 dividend bits; busy
//   stays high through ST_DIV and ST_DIV_DONE until the result is registered.
//   Seed with save: busy is high while the two 64x32 hash products go through
//   one 32x32 multiplier in four ST_MUL passes, ending with ST_MUL_LAST.
// Reset:
//   Synchronous, active high. Both generator words and both saved words
//   return to one; no transaction is in flight afterwards.
module xorshift_prng_with_seed_save_core (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   output logic                              busy,
   input  wire  [1:0]                        req_command,
   input  wire  [xsp_pkg::SEED_W-1:0]        req_seed,
   input  wire  signed [xsp_pkg::WORD_W-1:0] req_modulus,
   output logic                              rsp_valid,
   output logic [xsp_pkg::WORD_W-1:0]        rsp_value
);
   import xsp_pkg::*;

   ctrl_cmd_type cmd;
   logic         mod_ok;
   command_type  command;

   assign command = command_type'(req_command);

   xsp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (command),
      .mod_ok      (mod_ok),
      .busy        (busy),
      .cmd         (cmd)
   );

   xsp_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_seed    (req_seed),
      .req_modulus (req_modulus),
      .cmd         (cmd),
      .mod_ok      (mod_ok),
      .rsp_valid   (rsp_valid),
      .rsp_value   (rsp_value)
   );

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while a transaction is in progress");

   a_raw_next: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && command == CMD_RAW) |=> rsp_valid)
      else $error("raw step did not return in one cycle");

   a_restore_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && command == CMD_RESTORE) |=> (rsp_valid && rsp_value == '0))
      else $error("restore did not return zero");

   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without an accepted transaction");

endmodule

`default_nettype wire
